// File: sv/mlfq_pkg.sv
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared types, codes and helpers of the feedback-queue scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

  localparam int SLOTS_DEF = 64;
  localparam int NUM_LEVELS = 4;

  localparam logic [1:0] LOWEST_LEVEL = 2'd3;

  localparam logic [2:0] ST_UNUSED   = 3'd0;
  localparam logic [2:0] ST_USED     = 3'd1;
  localparam logic [2:0] ST_SLEEPING = 3'd2;
  localparam logic [2:0] ST_RUNNABLE = 3'd3;
  localparam logic [2:0] ST_RUNNING  = 3'd4;
  localparam logic [2:0] ST_ZOMBIE   = 3'd5;

  localparam logic [2:0] F_ALLOC    = 3'd0;
  localparam logic [2:0] F_RUNNABLE = 3'd1;
  localparam logic [2:0] F_TICK     = 3'd2;
  localparam logic [2:0] F_PICK     = 3'd3;
  localparam logic [2:0] F_SLEEP    = 3'd4;
  localparam logic [2:0] F_WAKE     = 3'd5;
  localparam logic [2:0] F_EXIT     = 3'd6;
  localparam logic [2:0] F_FREE     = 3'd7;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NO_FREE = 2'd1;
  localparam logic [1:0] STAT_IDLE    = 2'd2;

  localparam logic [2:0] CFG_Q0    = 3'd0;
  localparam logic [2:0] CFG_Q1    = 3'd1;
  localparam logic [2:0] CFG_Q2    = 3'd2;
  localparam logic [2:0] CFG_Q3    = 3'd3;
  localparam logic [2:0] CFG_BOOST = 3'd4;

  localparam logic [7:0]  Q0_RST    = 8'd4;
  localparam logic [7:0]  Q1_RST    = 8'd8;
  localparam logic [7:0]  Q2_RST    = 8'd16;
  localparam logic [7:0]  Q3_RST    = 8'd32;
  localparam logic [15:0] BOOST_RST = 16'd200;

  typedef struct packed {
    logic [2:0]  func;
    logic [5:0]  slot;
    logic [15:0] channel;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] chosen_slot;
    logic       preempt;
    logic [1:0] current_level;
  } out_t;

  typedef struct packed {
    logic [2:0]  state;
    logic [1:0]  level;
    logic [7:0]  ticks;
    logic [7:0]  run;
    logic [15:0] channel;
  } rec_t;

  typedef logic [NUM_LEVELS-1:0][7:0] quanta_t;

  typedef struct packed {
    logic [2:0]  func;
    logic        boost;
    rec_t        rec;
    logic [15:0] channel;
    logic [1:0]  serving;
    logic        tick_due;
    quanta_t     quantum;
  } alu_in_t;

  typedef struct packed {
    logic we;
    rec_t rec;
    logic preempt;
  } alu_out_t;

  function automatic logic [7:0] quantum_of(quanta_t q, logic [1:0] lvl);
    logic [7:0] v;
    v = q[lvl];
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

endpackage

// File: sv/mlfq_slot_table.sv
// ----------------------------------------------------------------------------
// mlfq_slot_table
// Task slot record memory with per-entry valid bits; unwritten entries
// read as an unused slot.
// ----------------------------------------------------------------------------
module mlfq_slot_table #(
  parameter int SLOTS = mlfq_pkg::SLOTS_DEF,
  parameter int IW = 6
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            rd_en,
  input  logic [IW-1:0]   rd_addr,
  output mlfq_pkg::rec_t  rd_data,
  input  logic            wr_en,
  input  logic [IW-1:0]   wr_addr,
  input  mlfq_pkg::rec_t  wr_data
);
  import mlfq_pkg::*;

  rec_t             mem [SLOTS];
  logic [SLOTS-1:0] vld;
  rec_t             rd_raw;
  logic             rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  always_comb begin
    rd_data = rd_raw;
    if (!rd_vld) begin
      rd_data.state = ST_UNUSED;
      rd_data.level = 2'd0;
      rd_data.ticks = 8'd0;
      rd_data.run   = 8'd0;
    end
  end

endmodule

// File: sv/mlfq_slot_alu.sv
// ----------------------------------------------------------------------------
// mlfq_slot_alu
// Shared slot record update unit: applies one command to one record.
// ----------------------------------------------------------------------------
module mlfq_slot_alu (
  input  mlfq_pkg::alu_in_t  ai,
  output mlfq_pkg::alu_out_t ao
);
  import mlfq_pkg::*;

  rec_t       r;
  logic [7:0] t;
  logic [7:0] rc;
  logic [7:0] cap;

  always_comb begin
    r   = ai.rec;
    t   = r.ticks - 8'd1;
    rc  = r.run + 8'd1;
    cap = quantum_of(ai.quantum, LOWEST_LEVEL);
    ao  = '0;
    ao.rec = r;
    if (ai.boost) begin
      ao.we        = 1'b1;
      ao.rec.level = 2'd0;
      ao.rec.ticks = quantum_of(ai.quantum, 2'd0);
      ao.rec.run   = 8'd0;
    end else begin
      case (ai.func)
        F_ALLOC: begin
          if (r.state == ST_UNUSED) begin
            ao.we        = 1'b1;
            ao.rec.state = ST_USED;
            ao.rec.level = 2'd0;
            ao.rec.ticks = quantum_of(ai.quantum, 2'd0);
            ao.rec.run   = 8'd0;
          end
        end
        F_RUNNABLE: begin
          if (r.state == ST_USED || r.state == ST_RUNNING) begin
            ao.we        = 1'b1;
            ao.rec.state = ST_RUNNABLE;
          end
        end
        F_TICK: begin
          if (r.state == ST_RUNNING) begin
            ao.we        = 1'b1;
            ao.rec.ticks = t;
            ao.rec.run   = rc;
            if (ai.tick_due) begin
              ao.preempt = 1'b1;
            end else if (t != 8'd0) begin
              ao.preempt = 1'b0;
            end else if (r.level != LOWEST_LEVEL) begin
              ao.rec.level = r.level + 2'd1;
              ao.rec.ticks = quantum_of(ai.quantum, r.level + 2'd1);
              ao.rec.run   = 8'd0;
              ao.preempt   = 1'b1;
            end else if (rc < cap) begin
              ao.rec.ticks = cap - rc;
            end else begin
              ao.rec.ticks = cap;
              ao.rec.run   = 8'd0;
              ao.preempt   = 1'b1;
            end
            if (ao.preempt) begin
              ao.rec.state = ST_RUNNABLE;
            end
          end
        end
        F_PICK: begin
          if (r.state == ST_RUNNABLE && r.level == ai.serving) begin
            ao.we        = 1'b1;
            ao.rec.state = ST_RUNNING;
          end
        end
        F_SLEEP: begin
          if (r.state == ST_RUNNING) begin
            ao.we          = 1'b1;
            ao.rec.state   = ST_SLEEPING;
            ao.rec.channel = ai.channel;
          end
        end
        F_WAKE: begin
          if (r.state == ST_SLEEPING && r.channel == ai.channel) begin
            ao.we        = 1'b1;
            ao.rec.state = ST_RUNNABLE;
          end
        end
        F_EXIT: begin
          if (r.state != ST_UNUSED) begin
            ao.we        = 1'b1;
            ao.rec.state = ST_ZOMBIE;
          end
        end
        default: begin
          ao.we        = 1'b1;
          ao.rec.state = ST_UNUSED;
          ao.rec.level = 2'd0;
          ao.rec.ticks = 8'd0;
          ao.rec.run   = 8'd0;
        end
      endcase
    end
  end

endmodule

// File: sv/mlfq_process_scheduler_top.sv
// Slot commands read and update one record; alloc and wake visit the slots
// in turn (up to SLOTS); pick scans the slots with a pass end after each full
// scan, and a priority boost first visits every slot. One item at a time; the single
// read port of the slot memory and the shared update unit serialize the work.
// Reset (rst, synchronous): all slots unused, registers at defaults, no clearing pass.
// ----------------------------------------------------------------------------
// mlfq_process_scheduler_top
// Four-level feedback-queue scheduler: sequencer over the slot table.
// ----------------------------------------------------------------------------
module mlfq_process_scheduler_top #(
  parameter int SLOTS = mlfq_pkg::SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_idx,
  input  logic [15:0]    cfg_wdata,
  input  logic           in_valid,
  output logic           in_ready,
  input  mlfq_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output mlfq_pkg::out_t out_data
);
  import mlfq_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PW = $clog2(SLOTS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EV   = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_PEND = 3'd4;

  logic [2:0]    state;
  logic [2:0]    func;
  logic [15:0]   chan;
  logic          boosting;
  logic [PW-1:0] idx;
  logic [PW-1:0] scan_ptr;
  logic          pass_found;
  logic [1:0]    serving;
  logic [15:0]   gticks;
  logic [PW-1:0] rcnt [NUM_LEVELS];
  quanta_t       quantum;
  logic [15:0]   bperiod;
  logic [1:0]    res_status;
  logic [5:0]    res_chosen;
  logic          res_preempt;

  logic          rd_en;
  logic [IW-1:0] rd_addr;
  rec_t          rd_data;
  alu_in_t       ai;
  alu_out_t      ao;
  logic [15:0]   gt_inc;
  logic          any_run;
  logic          pass_end;
  logic          last;
  logic          wr_en;
  logic          slot_ok;
  logic [PW-1:0] rtotal;
  logic [1:0]    min_level;

  assign in_ready = (state == S_IDLE);
  assign gt_inc   = (gticks == 16'hFFFF) ? gticks : gticks + 16'd1;
  assign any_run  = (rcnt[0] != '0) || (rcnt[1] != '0) || (rcnt[2] != '0) || (rcnt[3] != '0);
  assign rtotal   = PW'(rcnt[0] + rcnt[1] + rcnt[2] + rcnt[3]);
  assign pass_end = (scan_ptr >= PW'(SLOTS));
  assign last     = (idx == PW'(SLOTS - 1));
  assign slot_ok  = (32'(in_data.slot) < SLOTS);
  assign rd_en    = (state == S_RD) || (state == S_SCAN && !pass_end);
  assign rd_addr  = (state == S_RD) ? idx[IW-1:0] : scan_ptr[IW-1:0];
  assign wr_en    = (state == S_EV) && ao.we;

  always_comb begin
    if (rcnt[0] != '0) begin
      min_level = 2'd0;
    end else if (rcnt[1] != '0) begin
      min_level = 2'd1;
    end else if (rcnt[2] != '0) begin
      min_level = 2'd2;
    end else begin
      min_level = LOWEST_LEVEL;
    end
  end

  always_comb begin
    ai.func     = func;
    ai.boost    = boosting;
    ai.rec      = rd_data;
    ai.channel  = chan;
    ai.serving  = serving;
    ai.tick_due = (gt_inc >= bperiod);
    ai.quantum  = quantum;
  end

  mlfq_slot_table #(.SLOTS(SLOTS), .IW(IW)) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (idx[IW-1:0]),
    .wr_data (ao.rec)
  );

  mlfq_slot_alu u_alu (
    .ai (ai),
    .ao (ao)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      boosting   <= 1'b0;
      scan_ptr   <= '0;
      pass_found <= 1'b0;
      serving    <= 2'd0;
      gticks     <= 16'd0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        rcnt[l] <= '0;
      end
      quantum    <= {Q3_RST, Q2_RST, Q1_RST, Q0_RST};
      bperiod    <= BOOST_RST;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_Q0:    quantum[0] <= cfg_wdata[7:0];
          CFG_Q1:    quantum[1] <= cfg_wdata[7:0];
          CFG_Q2:    quantum[2] <= cfg_wdata[7:0];
          CFG_Q3:    quantum[3] <= cfg_wdata[7:0];
          CFG_BOOST: bperiod    <= cfg_wdata;
          default: ;
        endcase
      end

      if (state == S_PEND && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (wr_en && !boosting) begin
        for (int l = 0; l < NUM_LEVELS; l++) begin
          rcnt[l] <= rcnt[l]
            + PW'((ao.rec.state == ST_RUNNABLE) && (ao.rec.level == 2'(l)))
            - PW'((rd_data.state == ST_RUNNABLE) && (rd_data.level == 2'(l)));
        end
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            func        <= in_data.func;
            chan        <= in_data.channel;
            res_status  <= STAT_OK;
            res_chosen  <= 6'd0;
            res_preempt <= 1'b0;
            idx         <= '0;
            case (in_data.func)
              F_ALLOC, F_WAKE: state <= S_RD;
              F_PICK: begin
                if (!any_run) begin
                  res_status <= STAT_IDLE;
                  state      <= S_PEND;
                end else if (gticks >= bperiod) begin
                  gticks     <= 16'd0;
                  serving    <= 2'd0;
                  scan_ptr   <= '0;
                  pass_found <= 1'b0;
                  rcnt[0]    <= rtotal;
                  rcnt[1]    <= '0;
                  rcnt[2]    <= '0;
                  rcnt[3]    <= '0;
                  boosting   <= 1'b1;
                  state      <= S_RD;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
                if (slot_ok) begin
                  idx   <= PW'(in_data.slot);
                  state <= S_RD;
                end else begin
                  state <= S_PEND;
                end
              end
            endcase
          end
        end
        S_RD: state <= S_EV;
        S_SCAN: begin
          if (pass_end) begin
            if (!pass_found) begin
              serving <= (serving != LOWEST_LEVEL) ? serving + 2'd1 : min_level;
            end
            scan_ptr   <= '0;
            pass_found <= 1'b0;
          end else begin
            idx      <= scan_ptr;
            scan_ptr <= scan_ptr + PW'(1);
            state    <= S_EV;
          end
        end
        S_EV: begin
          if (boosting) begin
            if (last) begin
              boosting <= 1'b0;
              state    <= S_SCAN;
            end else begin
              idx   <= idx + PW'(1);
              state <= S_RD;
            end
          end else begin
            case (func)
              F_ALLOC: begin
                if (ao.we) begin
                  res_chosen <= 6'(idx);
                  serving    <= 2'd0;
                  state      <= S_PEND;
                end else if (last) begin
                  res_status <= STAT_NO_FREE;
                  state      <= S_PEND;
                end else begin
                  idx   <= idx + PW'(1);
                  state <= S_RD;
                end
              end
              F_WAKE: begin
                if (ao.we && rd_data.level < serving) begin
                  serving <= rd_data.level;
                end
                if (last) begin
                  state <= S_PEND;
                end else begin
                  idx   <= idx + PW'(1);
                  state <= S_RD;
                end
              end
              F_PICK: begin
                if (ao.we) begin
                  pass_found <= 1'b1;
                  res_chosen <= 6'(idx);
                  state      <= S_PEND;
                end else begin
                  state <= S_SCAN;
                end
              end
              F_TICK: begin
                if (ao.we) begin
                  gticks      <= gt_inc;
                  res_preempt <= ao.preempt;
                end
                state <= S_PEND;
              end
              default: state <= S_PEND;
            endcase
          end
        end
        S_PEND: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_PEND && (!out_valid || out_ready)) begin
      out_data.status        <= res_status;
      out_data.chosen_slot   <= res_chosen;
      out_data.preempt       <= res_preempt;
      out_data.current_level <= serving;
    end
  end

endmodule

// File: tb/sv/mlfq_process_scheduler_top_tb.sv
// ----------------------------------------------------------------------------
// mlfq_process_scheduler_top_tb
// Drives command items into the scheduler through random idle and stall
// phases and across several register settings. Each result is checked
// against a local model of the slot table.
// ----------------------------------------------------------------------------
module mlfq_process_scheduler_top_tb;
  import mlfq_pkg::*;

  localparam int NSLOT = 64;

  class sched_scoreboard;
    logic [7:0]  q[4];
    logic [15:0] period;
    logic [2:0]  st[NSLOT];
    logic [1:0]  lvl[NSLOT];
    logic [7:0]  left[NSLOT];
    logic [7:0]  runs[NSLOT];
    logic [15:0] chan[NSLOT];
    logic [1:0]  serving;
    logic [15:0] gticks;
    int          ptr;
    bit          found;
    out_t        pending[$];
    int          errors;

    function new();
      q[0] = Q0_RST; q[1] = Q1_RST; q[2] = Q2_RST; q[3] = Q3_RST;
      period = BOOST_RST;
      for (int i = 0; i < NSLOT; i++) begin
        st[i] = ST_UNUSED; lvl[i] = 0; left[i] = 0; runs[i] = 0; chan[i] = 0;
      end
      serving = 0; gticks = 0; ptr = 0; found = 0; errors = 0;
    endfunction

    function logic [7:0] slice(int l);
      return (q[l] == 0) ? 8'd1 : q[l];
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] v);
      case (idx)
        CFG_Q0: q[0] = v[7:0];
        CFG_Q1: q[1] = v[7:0];
        CFG_Q2: q[2] = v[7:0];
        CFG_Q3: q[3] = v[7:0];
        CFG_BOOST: period = v;
        default: ;
      endcase
    endfunction

    function bit charge_tick(int s);
      logic [7:0] cap;
      left[s] = left[s] - 8'd1;
      runs[s] = runs[s] + 8'd1;
      if (gticks != 16'hFFFF) gticks++;
      if (gticks >= period) return 1;
      if (left[s] != 0) return 0;
      if (lvl[s] != LOWEST_LEVEL) begin
        lvl[s] = lvl[s] + 2'd1;
        left[s] = slice(lvl[s]);
        runs[s] = 0;
        return 1;
      end
      cap = slice(3);
      if (runs[s] < cap) begin
        left[s] = cap - runs[s];
        return 0;
      end
      left[s] = cap;
      runs[s] = 0;
      return 1;
    endfunction

    function int next_to_run();
      bit any;
      int i;
      any = 0;
      foreach (st[k]) if (st[k] == ST_RUNNABLE) any = 1;
      if (!any) return -1;
      if (gticks >= period) begin
        for (int k = 0; k < NSLOT; k++) begin
          runs[k] = 0; lvl[k] = 0; left[k] = slice(0);
        end
        gticks = 0; serving = 0; ptr = 0; found = 0;
      end
      for (int it = 0; it < 8 * NSLOT + 8; it++) begin
        if (ptr >= NSLOT) begin
          if (!found) begin
            if (serving != LOWEST_LEVEL) serving++;
            else
              for (int k = 0; k < NSLOT; k++)
                if (st[k] == ST_RUNNABLE && lvl[k] < serving) serving = lvl[k];
          end
          ptr = 0; found = 0;
          continue;
        end
        i = ptr;
        ptr++;
        if (st[i] == ST_RUNNABLE && lvl[i] == serving) begin
          st[i] = ST_RUNNING;
          found = 1;
          return i;
        end
      end
      return -1;
    endfunction

    function void note_command(in_t c);
      out_t r;
      int s, p;
      s = int'(c.slot);
      r = '0;
      case (c.func)
        F_ALLOC: begin
          r.status = STAT_NO_FREE;
          for (int i = 0; i < NSLOT; i++)
            if (st[i] == ST_UNUSED) begin
              st[i] = ST_USED; lvl[i] = 0; left[i] = slice(0); runs[i] = 0;
              serving = 0; r.status = STAT_OK; r.chosen_slot = 6'(i);
              break;
            end
        end
        F_RUNNABLE:
          if (st[s] == ST_USED || st[s] == ST_RUNNING) st[s] = ST_RUNNABLE;
        F_TICK:
          if (st[s] == ST_RUNNING) begin
            r.preempt = charge_tick(s);
            if (r.preempt) st[s] = ST_RUNNABLE;
          end
        F_PICK: begin
          p = next_to_run();
          if (p < 0) r.status = STAT_IDLE;
          else r.chosen_slot = 6'(p);
        end
        F_SLEEP:
          if (st[s] == ST_RUNNING) begin
            chan[s] = c.channel; st[s] = ST_SLEEPING;
          end
        F_WAKE:
          for (int i = 0; i < NSLOT; i++)
            if (st[i] == ST_SLEEPING && chan[i] == c.channel) begin
              st[i] = ST_RUNNABLE;
              if (lvl[i] < serving) serving = lvl[i];
            end
        F_EXIT:
          if (st[s] != ST_UNUSED) st[s] = ST_ZOMBIE;
        default: begin
          st[s] = ST_UNUSED; lvl[s] = 0; left[s] = 0; runs[s] = 0;
        end
      endcase
      r.current_level = serving;
      pending.push_back(r);
    endfunction

    function void check_result(out_t a);
      out_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, a.status); errors++;
      end
      if (a.chosen_slot !== e.chosen_slot) begin
        $error("chosen_slot exp %0d got %0d", e.chosen_slot, a.chosen_slot); errors++;
      end
      if (a.preempt !== e.preempt) begin
        $error("preempt exp %0d got %0d", e.preempt, a.preempt); errors++;
      end
      if (a.current_level !== e.current_level) begin
        $error("current_level exp %0d got %0d", e.current_level, a.current_level);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [2:0]  cfg_idx = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 0;
  out_t        out_data;

  int send_idle = 0;
  int recv_stall = 0;
  longint cycles = 0;
  sched_scoreboard sb;
  logic [15:0] chan_pool[4] = '{16'h0000, 16'hFFFF, 16'h5A5A, 16'h1234};

  mlfq_process_scheduler_top DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 4000000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic send_item(in_t c);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_valid <= 1;
    in_data <= c;
    do @(posedge clk); while (!in_ready);
    sb.note_command(c);
  endtask

  task automatic send_cmd(logic [2:0] f, logic [5:0] s, logic [15:0] ch);
    in_t c;
    c.func = f; c.slot = s; c.channel = ch;
    send_item(c);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] v);
    cfg_we <= 1; cfg_idx <= idx; cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  task automatic random_item();
    in_t c;
    int r;
    r = $urandom_range(99);
    c.slot = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(7));
    c.channel = ($urandom_range(3) == 0) ? 16'($urandom) : chan_pool[$urandom_range(3)];
    if (r < 10) c.func = F_ALLOC;
    else if (r < 22) c.func = F_RUNNABLE;
    else if (r < 52) c.func = F_TICK;
    else if (r < 72) c.func = F_PICK;
    else if (r < 80) c.func = F_SLEEP;
    else if (r < 88) c.func = F_WAKE;
    else if (r < 93) c.func = F_EXIT;
    else c.func = F_FREE;
    send_item(c);
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_cmd(F_PICK, 0, 0);
    send_cmd(F_ALLOC, 0, 0);
    send_cmd(F_ALLOC, 0, 0);
    send_cmd(F_RUNNABLE, 0, 0);
    send_cmd(F_RUNNABLE, 6'd63, 0);
    send_cmd(F_PICK, 0, 0);
    for (int i = 0; i < 5; i++) send_cmd(F_TICK, 0, 0);
    send_cmd(F_PICK, 0, 0);
    send_cmd(F_SLEEP, 0, 16'hFFFF);
    send_cmd(F_WAKE, 0, 16'h0000);
    send_cmd(F_WAKE, 0, 16'hFFFF);
    send_cmd(F_EXIT, 6'd1, 0);
    send_cmd(F_EXIT, 6'd63, 0);
    send_cmd(F_FREE, 6'd1, 0);
    send_cmd(F_FREE, 6'd63, 0);
    for (int i = 0; i < 62; i++) send_cmd(F_ALLOC, 0, 0);
    send_cmd(F_ALLOC, 0, 0);
    send_cmd(F_ALLOC, 0, 0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 50; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 50; end
        3: begin send_idle = 32; recv_stall = 32; end
        default: begin send_idle = $urandom_range(60); recv_stall = $urandom_range(60); end
      endcase
      case (ph)
        0: begin
          write_reg(CFG_Q0, 1); write_reg(CFG_Q1, 1); write_reg(CFG_Q2, 1);
          write_reg(CFG_Q3, 1); write_reg(CFG_BOOST, 1);
        end
        1: begin
          write_reg(CFG_Q0, 255); write_reg(CFG_Q1, 255); write_reg(CFG_Q2, 255);
          write_reg(CFG_Q3, 255); write_reg(CFG_BOOST, 16'hFFFF);
        end
        2: begin
          write_reg(CFG_Q0, 0); write_reg(CFG_Q1, 2); write_reg(CFG_Q2, 3);
          write_reg(CFG_Q3, 0); write_reg(CFG_BOOST, 0);
        end
        default: begin
          write_reg(CFG_Q0, 16'($urandom_range(1, 4)));
          write_reg(CFG_Q1, 16'($urandom_range(1, 6)));
          write_reg(CFG_Q2, 16'($urandom_range(1, 8)));
          write_reg(CFG_Q3, 16'($urandom_range(1, 10)));
          write_reg(CFG_BOOST, 16'($urandom_range(5, 80)));
        end
      endcase
      cfg_we <= 0;
      for (int i = 0; i < 16; i++) send_cmd(F_FREE, 6'(i), 0);
      for (int i = 0; i < 70; i++) begin
        random_item();
        if (ph == 3 && i == 50) begin
          in_valid <= 0;
          @(posedge clk);
          while (sb.pending.size() != 0) @(posedge clk);
        end
      end
      drain();
    end
    send_idle = 0; recv_stall = 0;
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
